FILE: hw/rtl/hnm_pkg.sv
// shared constants and types of the height to normal map block
package hnm_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

    localparam int DIM_W = 9;   // configuration register width
    localparam int CRD_W = 8;   // coordinate field width
    localparam int HGT_W = 8;   // height byte

    localparam int S_W     = 23;  // squared length of the raw normal
    localparam int RS_W    = 17;  // reciprocal square root result
    localparam int RS_LIM_W = 53; // 2^52 bound
    localparam int RS_BIT_W = $clog2(RS_W);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_COMPUTE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_WR,
        ST_RD,
        ST_SQ,
        ST_RS,
        ST_MUL,
        ST_CNV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic           start;
        logic [S_W-1:0] s;
    } t_rs_req;

    typedef struct packed {
        logic            done;
        logic [RS_W-1:0] root;
    } t_rs_rsp;

endpackage

FILE: hw/rtl/height_to_normal_map.sv
// top level of the height to normal map block
//
// input channel (i_in_valid / o_in_stall) carries one item: mode, row, col
// and height_value. a load item writes the height byte into the store and
// gives no result; a compute item gives one result item on the output
// channel (o_out_valid / i_out_stall) with the rgb normal and the pixel.
// row and col are first reduced modulo the map size by an 8 step
// restoring divider, one bit a cycle.
// a load item passes the reduce steps and the write before it returns to
// idle; a compute item passes 8 reduce steps, 9 neighbour reads through
// the single read port, the squared length, 17 rsqrt steps and a handoff,
// three multiply and byte passes and the output register step before it
// returns to idle, where the next item is accepted.
// one item is worked at a time; o_in_stall is high while an item is in work.
// the result sits in an output register, so the next item is taken while a
// result still waits; a finished result waits in its last state only if
// the output register is still full and stalled.
// config writes (i_cfg_we, i_cfg_index, i_cfg_data) must come only while idle.
// synchronous reset sets both dimensions to 256 and empties the output;
// the store is not cleared and must be loaded before it is read.
module height_to_normal_map (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hnm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hnm_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [hnm_pkg::CRD_W-1:0]     i_row,
    input  logic [hnm_pkg::CRD_W-1:0]     i_col,
    input  logic [hnm_pkg::HGT_W-1:0]     i_height_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_normal_red,
    output logic [7:0]                    o_normal_green,
    output logic [7:0]                    o_normal_blue,
    output logic [hnm_pkg::CRD_W-1:0]     o_out_row,
    output logic [hnm_pkg::CRD_W-1:0]     o_out_col
);
    import hnm_pkg::*;

    localparam logic signed [11:0] Z_SUM = 12'sd2040;

    // x weight of neighbour k, counter-clockwise from (r, c+1)
    function automatic logic signed [2:0] wx(input logic [2:0] k);
        logic signed [2:0] w;
        case (k)
            3'd0:    w = -3'sd2;
            3'd1:    w = -3'sd1;
            3'd3:    w = 3'sd1;
            3'd4:    w = 3'sd2;
            3'd5:    w = 3'sd1;
            3'd7:    w = -3'sd1;
            default: w = 3'sd0;
        endcase
        return w;
    endfunction

    function automatic logic signed [2:0] wy(input logic [2:0] k);
        logic signed [2:0] w;
        case (k)
            3'd1:    w = -3'sd1;
            3'd2:    w = -3'sd2;
            3'd3:    w = -3'sd1;
            3'd5:    w = 3'sd1;
            3'd6:    w = 3'sd2;
            3'd7:    w = 3'sd1;
            default: w = 3'sd0;
        endcase
        return w;
    endfunction

    // configuration
    logic [DIM_W-1:0] r_map_width;
    logic [DIM_W-1:0] r_map_height;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= DIM_W'(256);
            r_map_height <= DIM_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                CFG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize saturates
    always_comb begin
        if (r_map_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (int'(r_map_width) > MAX_WIDTH) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = r_map_width;
        end
        if (r_map_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (int'(r_map_height) > MAX_HEIGHT) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_map_height;
        end
    end

    // control and datapath state
    t_state r_state, n_state;
    logic [3:0]        r_cnt;
    logic              r_mode;
    logic [CRD_W-1:0]  r_div_r, r_div_c;
    logic [CRD_W-1:0]  r_rem_r, r_rem_c;
    logic [HGT_W-1:0]  r_hv;
    logic signed [11:0] r_x, r_y;
    logic [RS_W-1:0]   r_root;
    logic [28:0]       r_mag;
    logic              r_neg;
    logic [7:0]        r_byte [0:2];
    logic              r_out_valid;
    logic [7:0]        r_out_red, r_out_green, r_out_blue;
    logic [CRD_W-1:0]  r_out_row, r_out_col;

    // restoring remainder step
    logic [DIM_W-1:0] n_tr, n_tc;
    logic [CRD_W-1:0] n_rem_r, n_rem_c;

    always_comb begin
        n_tr    = {r_rem_r, r_div_r[CRD_W-1]};
        n_tc    = {r_rem_c, r_div_c[CRD_W-1]};
        n_rem_r = (n_tr >= h_eff) ? CRD_W'(n_tr - h_eff) : CRD_W'(n_tr);
        n_rem_c = (n_tc >= w_eff) ? CRD_W'(n_tc - w_eff) : CRD_W'(n_tc);
    end

    // wrap-around neighbours
    logic [CRD_W-1:0] rp, rm, cp, cm, nb_r, nb_c;
    logic [ADDR_W-1:0] rd_addr, wr_addr;

    always_comb begin
        rp = (DIM_W'(r_rem_r) + 1'b1 == h_eff) ? '0 : r_rem_r + 1'b1;
        rm = (r_rem_r == '0) ? CRD_W'(h_eff - 1'b1) : r_rem_r - 1'b1;
        cp = (DIM_W'(r_rem_c) + 1'b1 == w_eff) ? '0 : r_rem_c + 1'b1;
        cm = (r_rem_c == '0) ? CRD_W'(w_eff - 1'b1) : r_rem_c - 1'b1;
        case (r_cnt[2:0])
            3'd0:    begin nb_r = r_rem_r; nb_c = cp;      end
            3'd1:    begin nb_r = rm;      nb_c = cp;      end
            3'd2:    begin nb_r = rm;      nb_c = r_rem_c; end
            3'd3:    begin nb_r = rm;      nb_c = cm;      end
            3'd4:    begin nb_r = r_rem_r; nb_c = cm;      end
            3'd5:    begin nb_r = rp;      nb_c = cm;      end
            3'd6:    begin nb_r = rp;      nb_c = r_rem_c; end
            default: begin nb_r = rp;      nb_c = cp;      end
        endcase
        rd_addr = {ROW_W'(nb_r), COL_W'(nb_c)};
        wr_addr = {ROW_W'(r_rem_r), COL_W'(r_rem_c)};
    end

    logic [HGT_W-1:0] rd_data;

    hnm_store u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_WR),
        .i_waddr (wr_addr),
        .i_wdata (r_hv),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // accumulation of the neighbour that was read last cycle
    logic [2:0]        acc_k;
    logic signed [11:0] n_x, n_y;
    logic signed [11:0] hd;

    always_comb begin
        acc_k = 3'(r_cnt - 1'b1);
        hd    = 12'(rd_data);
        n_x   = r_x + 12'(wx(acc_k) * hd);
        n_y   = r_y + 12'(wy(acc_k) * hd);
    end

    // squared length and rsqrt handoff
    logic [10:0] ax, ay;
    t_rs_req rs_req;
    t_rs_rsp rs_rsp;

    always_comb begin
        ax = r_x[11] ? 11'(-r_x) : 11'(r_x);
        ay = r_y[11] ? 11'(-r_y) : 11'(r_y);
        rs_req.start = (r_state == ST_SQ);
        rs_req.s     = S_W'(22'(ax) * 22'(ax)) + S_W'(22'(ay) * 22'(ay))
                     + S_W'(int'(Z_SUM) * int'(Z_SUM));
    end

    hnm_rsqrt u_rsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rs_req),
        .o_rsp   (rs_rsp)
    );

    // component select, magnitude and byte mapping
    logic signed [11:0] comp;
    logic [10:0]        acomp;
    logic [29:0]        mag_adj;
    logic [17:0]        u;
    logic [14:0]        uc;
    logic [15:0]        base;
    logic [23:0]        prod;
    logic [7:0]         n_byte;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    comp = r_x;
            2'd1:    comp = r_y;
            default: comp = Z_SUM;
        endcase
        acomp   = comp[11] ? 11'(-comp) : 11'(comp);
        mag_adj = r_neg ? 30'(r_mag) + 30'd4095 : 30'(r_mag);
        u       = mag_adj[29:12];
        uc      = (u > 18'd16384) ? 15'd16384 : u[14:0];
        base    = r_neg ? 16'd16384 - 16'(uc) : 16'd16384 + 16'(uc);
        prod    = 24'(base) * 24'd255;
        n_byte  = prod[22:15];
    end

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_MOD;
            ST_MOD: begin
                if (r_cnt == 4'd7) begin
                    n_state = (r_mode == MODE_LOAD) ? ST_WR : ST_RD;
                end
            end
            ST_WR:  n_state = ST_IDLE;
            ST_RD:  if (r_cnt == 4'd8) n_state = ST_SQ;
            ST_SQ:  n_state = ST_RS;
            ST_RS:  if (rs_rsp.done) n_state = ST_MUL;
            ST_MUL: n_state = ST_CNV;
            ST_CNV: n_state = (r_cnt[1:0] == 2'd2) ? ST_OUT : ST_MUL;
            ST_OUT: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case (r_state)
                ST_IDLE: r_cnt <= '0;
                ST_MOD:  r_cnt <= (r_cnt == 4'd7) ? 4'd0 : r_cnt + 1'b1;
                ST_RD:   r_cnt <= (r_cnt == 4'd8) ? 4'd0 : r_cnt + 1'b1;
                ST_CNV:  r_cnt <= r_cnt + 1'b1;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_mode  <= i_mode;
                r_div_r <= i_row;
                r_div_c <= i_col;
                r_hv    <= i_height_value;
                r_rem_r <= '0;
                r_rem_c <= '0;
                r_x     <= '0;
                r_y     <= '0;
            end
            ST_MOD: begin
                r_rem_r <= n_rem_r;
                r_rem_c <= n_rem_c;
                r_div_r <= r_div_r << 1;
                r_div_c <= r_div_c << 1;
            end
            ST_RD: begin
                if (r_cnt != '0) begin
                    r_x <= n_x;
                    r_y <= n_y;
                end
            end
            ST_RS: begin
                if (rs_rsp.done) r_root <= rs_rsp.root;
            end
            ST_MUL: begin
                r_mag <= 29'(acomp) * 29'(r_root);
                r_neg <= comp[11];
            end
            ST_CNV: r_byte[r_cnt[1:0]] <= n_byte;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_out_red   <= r_byte[0];
            r_out_green <= r_byte[1];
            r_out_blue  <= r_byte[2];
            r_out_row   <= r_rem_r;
            r_out_col   <= r_rem_c;
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_normal_red   = r_out_red;
    assign o_normal_green = r_out_green;
    assign o_normal_blue  = r_out_blue;
    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;

endmodule

FILE: hw/rtl/hnm_store.sv
// height store: one write port, one read port with registered data
module hnm_store (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [hnm_pkg::ADDR_W-1:0] i_waddr,
    input  logic [hnm_pkg::HGT_W-1:0]  i_wdata,
    input  logic [hnm_pkg::ADDR_W-1:0] i_raddr,
    output logic [hnm_pkg::HGT_W-1:0]  o_rdata
);
    import hnm_pkg::*;

    logic [HGT_W-1:0] r_mem [0:DEPTH-1];
    logic [HGT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/hnm_rsqrt.sv
// bit-serial reciprocal square root, largest r with r*r*s <= 2^52
module hnm_rsqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hnm_pkg::t_rs_req i_req,
    output hnm_pkg::t_rs_rsp o_rsp
);
    import hnm_pkg::*;

    localparam int Q_W    = RS_W + S_W;
    localparam int CAND_W = 2 * RS_W + S_W + 1;

    logic [S_W-1:0]      r_s;
    logic [RS_W-1:0]     r_root;
    logic [RS_LIM_W-1:0] r_p;     // root^2 * s
    logic [Q_W-1:0]      r_q;     // root * s
    logic [RS_BIT_W-1:0] r_bit;
    logic                r_busy;
    logic                r_done;

    logic [CAND_W-1:0] n_cand;
    logic              n_take;

    // (root + 2^b)^2 * s = p + q*2^(b+1) + s*2^(2b)
    always_comb begin
        n_cand = CAND_W'(r_p)
               + (CAND_W'(r_q) << ({1'b0, r_bit} + 6'd1))
               + (CAND_W'(r_s) << {r_bit, 1'b0});
        n_take = n_cand <= (CAND_W'(1) << (RS_LIM_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_s    <= i_req.s;
            r_root <= '0;
            r_p    <= '0;
            r_q    <= '0;
            r_bit  <= RS_BIT_W'(RS_W - 1);
        end else if (r_busy) begin
            if (n_take) begin
                r_root <= r_root | (RS_W'(1) << r_bit);
                r_p    <= n_cand[RS_LIM_W-1:0];
                r_q    <= r_q + (Q_W'(r_s) << r_bit);
            end
            if (r_bit != '0) begin
                r_bit <= r_bit - 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

FILE: dv/tb_top.sv
// self-checking testbench of the height to normal map block
module tb_top;
    import hnm_pkg::*;

    // config index with no register behind it, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd2;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 60;   // beyond the slowest item in work
    localparam int RAND_ITEMS  = 60;   // random items per setting

    typedef struct {
        logic             mode;
        logic [CRD_W-1:0] row;
        logic [CRD_W-1:0] col;
        logic [HGT_W-1:0] hgt;
    } t_pixel_item;

    typedef struct {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [CRD_W-1:0] row;
        logic [CRD_W-1:0] col;
    } t_normal_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_mode = 1'b0;
    logic [CRD_W-1:0]     i_row = '0;
    logic [CRD_W-1:0]     i_col = '0;
    logic [HGT_W-1:0]     i_height_value = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [7:0]           o_normal_red;
    logic [7:0]           o_normal_green;
    logic [7:0]           o_normal_blue;
    logic [CRD_W-1:0]     o_out_row;
    logic [CRD_W-1:0]     o_out_col;

    height_to_normal_map DUT (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // pending items, expected normals and the shadow state of the block
    t_pixel_item  pixel_queue[$];
    t_normal_item normal_queue[$];
    logic [7:0]   height_mirror[DEPTH];
    bit           loaded_addr[DEPTH];   // entries that some queued load writes
    int           width_reg = 256;
    int           height_reg = 256;
    int           plan_w = 256;          // dims in force for the items being queued
    int           plan_h = 256;

    int n_loads = 0, n_computes = 0, n_normals = 0, n_cfg = 0, n_fail = 0;
    longint cycles = 0;

    function automatic int eff_dim(int v, int mx);
        if (v == 0) return 1;
        if (v > mx) return mx;
        return v;
    endfunction

    function automatic longint unsigned inv_sqrt_q26(longint unsigned s);
        longint unsigned r, t;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t * s <= (64'd1 << 52)) r = t;
        end
        return r;
    endfunction

    // signed component scaled by the reciprocal length, then mapped to a byte
    function automatic logic [7:0] comp_to_byte(int v, longint unsigned r);
        longint unsigned mag;
        longint q;
        mag = longint'(v < 0 ? -v : v) * r;
        if (v >= 0) q = longint'(mag >> 12);
        else q = -longint'((mag + 4095) >> 12);
        if (q < -16384) q = -16384;
        if (q > 16384) q = 16384;
        return 8'((unsigned'(q + 16384) * 255) >> 15);
    endfunction

    function automatic int hgt_at(int r, int c);
        return int'(height_mirror[r * MAX_WIDTH + c]);
    endfunction

    // work out what one accepted item does to the mirror and what it yields
    task automatic apply_pixel_item(t_pixel_item it);
        int w, h, r, c, rp, rm, cp, cm, x, y;
        int n[8];
        longint unsigned s, rs;
        t_normal_item e;
        w = eff_dim(width_reg, MAX_WIDTH);
        h = eff_dim(height_reg, MAX_HEIGHT);
        r = int'(it.row) % h;
        c = int'(it.col) % w;
        if (it.mode == MODE_LOAD) begin
            height_mirror[r * MAX_WIDTH + c] = it.hgt;
            n_loads++;
        end else begin
            rp = (r + 1) % h;
            rm = (r != 0) ? r - 1 : h - 1;
            cp = (c + 1) % w;
            cm = (c != 0) ? c - 1 : w - 1;
            n[0] = hgt_at(r, cp);  n[1] = hgt_at(rm, cp);
            n[2] = hgt_at(rm, c);  n[3] = hgt_at(rm, cm);
            n[4] = hgt_at(r, cm);  n[5] = hgt_at(rp, cm);
            n[6] = hgt_at(rp, c);  n[7] = hgt_at(rp, cp);
            x = 2 * (n[4] - n[0]) + n[3] + n[5] - n[1] - n[7];
            y = 2 * (n[6] - n[2]) + n[5] + n[7] - n[1] - n[3];
            s = longint'(x * x) + longint'(y * y) + 64'd2040 * 64'd2040;
            rs = inv_sqrt_q26(s);
            e.red   = comp_to_byte(x, rs);
            e.green = comp_to_byte(y, rs);
            e.blue  = comp_to_byte(2040, rs);
            e.row   = CRD_W'(r);
            e.col   = CRD_W'(c);
            normal_queue.push_back(e);
            n_computes++;
        end
    endtask

    // ---------------- driver: bursts of items with random gaps ----------------
    int burst_left = 4, gap_left = 0;

    always @(posedge i_clk) begin
        t_pixel_item cur, nxt;
        cycles++;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                cur.mode = i_mode; cur.row = i_row; cur.col = i_col; cur.hgt = i_height_value;
                apply_pixel_item(cur);
            end
            // a stalled item stays put; otherwise maybe present the next one
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pixel_queue.size() > 0) begin
                    nxt = pixel_queue.pop_front();
                    i_in_valid     <= 1'b1;
                    i_mode         <= nxt.mode;
                    i_row          <= nxt.row;
                    i_col          <= nxt.col;
                    i_height_value <= nxt.hgt;
                    if (--burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        // some bursts run back to back, others leave a gap
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver stall pattern, with one long hold-off ----------------
    int seg_left = 0, seg_kind = 0, hold_left = 0;
    bit hold_done = 0;

    always @(posedge i_clk) begin
        if (!hold_done && n_computes >= 100) begin
            hold_done = 1;
            hold_left = 3000;   // block fills up and must stall its input
        end
        if (seg_left == 0) begin
            seg_left = $urandom_range(5, 200);
            seg_kind = $urandom_range(0, 3);
        end
        seg_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (seg_kind)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 1) == 1);
                2: i_out_stall <= ($urandom_range(0, 9) < 8);
                default: i_out_stall <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // ---------------- monitor: check each result item in order ----------------
    always @(posedge i_clk) begin
        t_normal_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (normal_queue.size() == 0) begin
                $error("unexpected result item row %0d col %0d", o_out_row, o_out_col);
                n_fail++;
            end else begin
                e = normal_queue.pop_front();
                n_normals++;
                if (o_normal_red !== e.red) begin
                    $error("normal_red expected %0d actual %0d", e.red, o_normal_red);
                    n_fail++;
                end
                if (o_normal_green !== e.green) begin
                    $error("normal_green expected %0d actual %0d", e.green, o_normal_green);
                    n_fail++;
                end
                if (o_normal_blue !== e.blue) begin
                    $error("normal_blue expected %0d actual %0d", e.blue, o_normal_blue);
                    n_fail++;
                end
                if (o_out_row !== e.row) begin
                    $error("out_row expected %0d actual %0d", e.row, o_out_row);
                    n_fail++;
                end
                if (o_out_col !== e.col) begin
                    $error("out_col expected %0d actual %0d", e.col, o_out_col);
                    n_fail++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic queue_load(int r, int c, int hv);
        t_pixel_item it;
        it.mode = MODE_LOAD; it.row = CRD_W'(r); it.col = CRD_W'(c); it.hgt = HGT_W'(hv);
        pixel_queue.push_back(it);
        loaded_addr[(r % eff_dim(plan_h, MAX_HEIGHT)) * MAX_WIDTH
                    + (c % eff_dim(plan_w, MAX_WIDTH))] = 1;
    endtask

    // compute item; first loads any neighbour that was never written
    task automatic queue_compute(int r, int c);
        int w, h, rr, cc, nr, nc;
        t_pixel_item it;
        w = eff_dim(plan_w, MAX_WIDTH);
        h = eff_dim(plan_h, MAX_HEIGHT);
        rr = r % h;
        cc = c % w;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                nr = (rr + dr + h) % h;
                nc = (cc + dc + w) % w;
                if (!loaded_addr[nr * MAX_WIDTH + nc]) queue_load(nr, nc, $urandom_range(0, 255));
            end
        end
        it.mode = MODE_COMPUTE; it.row = CRD_W'(r); it.col = CRD_W'(c);
        it.hgt = HGT_W'($urandom_range(0, 255));   // ignored, but toggled
        pixel_queue.push_back(it);
    endtask

    // sender pauses here until the block has drained completely
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixel_queue.size() > 0 || i_in_valid || normal_queue.size() > 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= DIM_W'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_MAP_WIDTH) width_reg = val;
        else if (idx == CFG_MAP_HEIGHT) height_reg = val;
        plan_w = width_reg;
        plan_h = height_reg;
        n_cfg++;
    endtask

    task automatic random_phase(int count);
        int r, c;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 255);
            c = $urandom_range(0, 255);
            // mostly in-range coordinates, some that must be reduced
            if ($urandom_range(0, 3) != 0) begin
                r = r % eff_dim(plan_h, MAX_HEIGHT);
                c = c % eff_dim(plan_w, MAX_WIDTH);
            end
            if ($urandom_range(0, 1) == 0) queue_load(r, c, $urandom_range(0, 255));
            else queue_compute(r, c);
        end
    endtask

    int dims_w[7] = '{256, 0, 511, 5, 2, 1, 16};
    int dims_h[7] = '{256, 0, 300, 7, 2, 256, 1};

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, at reset dims: steepest slopes with wrap at the corners
        queue_load(0, 255, 255); queue_load(255, 255, 255); queue_load(1, 255, 255);
        queue_load(0, 1, 0);     queue_load(255, 1, 0);     queue_load(1, 1, 0);
        queue_load(255, 0, 0);   queue_load(1, 0, 255);     queue_load(0, 0, 128);
        queue_compute(0, 0);
        queue_load(254, 254, 255); queue_load(254, 255, 255); queue_load(254, 0, 255);
        queue_compute(255, 255);
        queue_compute(255, 0);
        queue_compute(0, 0);
        wait_idle();

        // unused register index must change nothing
        write_cfg(CFG_NO_REG, 3);
        queue_compute(0, 0);
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            write_cfg(CFG_MAP_WIDTH, dims_w[p]);
            write_cfg(CFG_MAP_HEIGHT, dims_h[p]);
            // out-of-range coordinates, a compute and then a load
            if (p == 3) begin
                queue_compute(200, 201);
                queue_load(9, 13, 77);
            end
            random_phase(RAND_ITEMS);
            wait_idle();
        end
        write_cfg(CFG_MAP_WIDTH, $urandom_range(1, 300));
        write_cfg(CFG_MAP_HEIGHT, $urandom_range(1, 300));
        random_phase(RAND_ITEMS);
        wait_idle();

        $display("covered %0d loads, %0d computes, %0d results checked, %0d config writes",
                 n_loads, n_computes, n_normals, n_cfg);
        $display("settings: reset, zero, oversized, odd small, 1-wide, 1-high, random");
        if (n_fail == 0 && normal_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
